// File: rtl/core/vdp_pkg.sv
// Shared types, operation codes and constants of the video display host port.
package vdp_pkg;

    localparam int unsigned ADDR_W   = 14;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned OP_W     = 3;
    localparam int unsigned NUM_REGS = 8;
    localparam int unsigned REG_IDX_W = $clog2(NUM_REGS);

    localparam int unsigned VRAM_DEPTH_DEF     = 16384;
    localparam int unsigned IRQ_ENABLE_BIT_DEF = 5;

    typedef logic [OP_W-1:0]   t_op;
    typedef logic [BYTE_W-1:0] t_byte;
    typedef logic [ADDR_W-1:0] t_addr;

    localparam t_op OP_CTRL_WR   = 3'd0;
    localparam t_op OP_DATA_WR   = 3'd1;
    localparam t_op OP_DATA_RD   = 3'd2;
    localparam t_op OP_STATUS_RD = 3'd3;
    localparam t_op OP_FRAME     = 3'd4;

    // Second control byte: bit 7 picks a register write over an address load
    localparam int unsigned REG_WR_BIT = 7;
    localparam int unsigned ADDR_HI_W  = 6;

    localparam t_byte STATUS_FRAME = 8'h80;
    localparam t_byte STATUS_IDLE  = 8'h00;

endpackage

// File: rtl/core/vdp_in_if.sv
// Input channel of the host port: bus accesses.
interface vdp_in_if;
    logic               valid;
    logic               ready;
    vdp_pkg::t_op       operation;
    vdp_pkg::t_byte     bus_byte;

    modport source (output valid, output operation, output bus_byte, input ready);
    modport sink   (input valid, input operation, input bus_byte, output ready);
endinterface

// File: rtl/core/vdp_out_if.sv
// Output channel of the host port: one result per access.
interface vdp_out_if;
    logic               valid;
    logic               ready;
    vdp_pkg::t_byte     read_byte;
    logic               irq_line;

    modport source (output valid, output read_byte, output irq_line, input ready);
    modport sink   (input valid, input read_byte, input irq_line, output ready);
endinterface

// File: rtl/core/video_display_host_port.sv
// Host port of a video display processor: control, data and status accesses.
// An accepted access passes through the memory stage register, then the output register, to the output channel.
// Throughput: one access per cycle while no result is stalled; the video memory port takes one access a cycle.
// Input ready falls only while a result is held and the one behind it is stalled.
// Reset clears the control registers, address, byte latch, frame flag and pipeline;
// video memory contents stay undefined until written.
module video_display_host_port #(
    parameter int unsigned VRAM_DEPTH     = vdp_pkg::VRAM_DEPTH_DEF,
    parameter int unsigned IRQ_ENABLE_BIT = vdp_pkg::IRQ_ENABLE_BIT_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    vdp_in_if.sink       i_in,
    vdp_out_if.source    o_out
);
    import vdp_pkg::*;

    localparam int unsigned IDX_W = $clog2(VRAM_DEPTH);
    localparam int unsigned SUB_W = ADDR_W + 3;

    // architectural state
    t_byte r_ctrl [NUM_REGS];
    t_addr r_addr;
    logic  r_first;
    t_byte r_held;
    logic  r_frame;

    // memory stage and output register
    logic  r_s1_valid;
    logic  r_s1_rd;
    t_byte r_s1_byte;
    logic  r_s1_irq;
    logic  r_o_valid;
    t_byte r_o_byte;
    logic  r_o_irq;

    logic  n_first;
    t_byte n_held;
    t_addr n_addr;
    logic  n_frame;
    logic  n_ctrl_we;
    t_byte n_ctrl1;
    logic  n_rd;
    t_byte n_byte;

    logic  accept;
    logic  s1_adv;
    logic  mem_we;
    logic  mem_re;
    t_byte mem_rdata;
    logic [IDX_W-1:0] mem_idx;
    logic [SUB_W-1:0] sub1, sub2, sub3;
    logic [REG_IDX_W-1:0] reg_sel;

    assign s1_adv     = r_s1_valid && (!r_o_valid || o_out.ready);
    assign i_in.ready = !r_s1_valid || s1_adv;
    assign accept     = i_in.valid && i_in.ready;
    assign reg_sel    = i_in.bus_byte[REG_IDX_W-1:0];

    // address modulo depth: the quotient is at most three, so pick the lowest
    // non-negative difference
    always_comb begin
        sub1 = SUB_W'(r_addr) - SUB_W'(VRAM_DEPTH);
        sub2 = SUB_W'(r_addr) - SUB_W'(2 * VRAM_DEPTH);
        sub3 = SUB_W'(r_addr) - SUB_W'(3 * VRAM_DEPTH);
        priority if (!sub3[SUB_W-1]) begin
            mem_idx = sub3[IDX_W-1:0];
        end else if (!sub2[SUB_W-1]) begin
            mem_idx = sub2[IDX_W-1:0];
        end else if (!sub1[SUB_W-1]) begin
            mem_idx = sub1[IDX_W-1:0];
        end else begin
            mem_idx = r_addr[IDX_W-1:0];
        end
    end

    always_comb begin
        n_first   = r_first;
        n_held    = r_held;
        n_addr    = r_addr;
        n_frame   = r_frame;
        n_ctrl_we = 1'b0;
        n_rd      = 1'b0;
        n_byte    = STATUS_IDLE;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        unique case (i_in.operation)
            OP_CTRL_WR: begin
                if (!r_first) begin
                    n_held  = i_in.bus_byte;
                    n_first = 1'b1;
                end else begin
                    n_first = 1'b0;
                    if (i_in.bus_byte[REG_WR_BIT]) begin
                        n_ctrl_we = 1'b1;
                    end else begin
                        n_addr = {i_in.bus_byte[ADDR_HI_W-1:0], r_held};
                    end
                end
            end
            OP_DATA_WR: begin
                mem_we  = accept;
                n_addr  = r_addr + t_addr'(1);
                n_first = 1'b0;
            end
            OP_DATA_RD: begin
                mem_re  = accept;
                n_rd    = 1'b1;
                n_addr  = r_addr + t_addr'(1);
                n_first = 1'b0;
            end
            OP_STATUS_RD: begin
                n_byte  = r_frame ? STATUS_FRAME : STATUS_IDLE;
                n_frame = 1'b0;
                n_first = 1'b0;
            end
            OP_FRAME: begin
                n_frame = 1'b1;
            end
            default: begin
            end
        endcase
        // register one as it stands after this access
        n_ctrl1 = (n_ctrl_we && reg_sel == REG_IDX_W'(1)) ? r_held : r_ctrl[1];
    end

    vdp_vram #(
        .DEPTH (VRAM_DEPTH),
        .IDX_W (IDX_W)
    ) u_vram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_re    (mem_re),
        .i_idx   (mem_idx),
        .i_wdata (i_in.bus_byte),
        .o_rdata (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                r_ctrl[i] <= STATUS_IDLE;
            end
            r_addr     <= '0;
            r_first    <= 1'b0;
            r_held     <= '0;
            r_frame    <= 1'b0;
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (accept) begin
                r_addr  <= n_addr;
                r_first <= n_first;
                r_held  <= n_held;
                r_frame <= n_frame;
                if (n_ctrl_we) begin
                    r_ctrl[reg_sel] <= r_held;
                end
            end
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_o_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // payload of the pipeline
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_rd   <= n_rd;
            r_s1_byte <= n_byte;
            r_s1_irq  <= n_frame && n_ctrl1[IRQ_ENABLE_BIT];
        end
        if (s1_adv) begin
            r_o_byte <= r_s1_rd ? mem_rdata : r_s1_byte;
            r_o_irq  <= r_s1_irq;
        end
    end

    assign o_out.valid     = r_o_valid;
    assign o_out.read_byte = r_o_byte;
    assign o_out.irq_line  = r_o_irq;

endmodule

// File: rtl/core/vdp_vram.sv
// Video memory: single port, synchronous write, registered read.
module vdp_vram #(
    parameter int unsigned DEPTH = vdp_pkg::VRAM_DEPTH_DEF,
    parameter int unsigned IDX_W = $clog2(DEPTH)
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic                 i_re,
    input  logic [IDX_W-1:0]     i_idx,
    input  vdp_pkg::t_byte       i_wdata,
    output vdp_pkg::t_byte       o_rdata
);
    import vdp_pkg::*;

    t_byte r_mem [DEPTH];
    t_byte r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_idx] <= i_wdata;
        end
        // hold the last read word until the next read
        if (i_re) begin
            r_q <= r_mem[i_idx];
        end
    end

    assign o_rdata = r_q;

endmodule

// File: rtl/core/vdp_chk.sv
// Port checker of the host port, bound to the top level.
module vdp_chk (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           i_in_ready,
    input logic           i_out_valid,
    input logic           i_out_ready,
    input vdp_pkg::t_byte i_read_byte,
    input logic           i_irq_line
);
    import vdp_pkg::*;

    logic [1:0] r_count;
    logic       in_xfer;
    logic       out_xfer;

    assign in_xfer  = i_in_valid && i_in_ready;
    assign out_xfer = i_out_valid && i_out_ready;

    // count transfers in flight
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= r_count + 2'(in_xfer) - 2'(out_xfer);
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_read_byte) && $stable(i_irq_line))
        else $error("result changed while stalled");

    a_no_idle_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid && !i_out_ready)
        else $error("input stalled without a stalled result");

    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 2'd2)
        else $error("more than two transfers in flight");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> r_count != 2'd0)
        else $error("result with no access in flight");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind video_display_host_port vdp_chk u_vdp_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_read_byte (o_out.read_byte),
    .i_irq_line  (o_out.irq_line)
);
